// ----- hdl/ihl_pkg.sv -----
// Shared types, codes and helper functions for the Intel HEX image loader.
// Depends on nothing; the loader top level, the checker and the testbench import it.
package ihl_pkg;

    // Default image address width; the image holds 2**ADDRESS_BITS bytes.
    localparam int IHL_ADDRESS_BITS = 16;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  character;
        logic [15:0] read_address;
    } ihl_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  status;
        logic [23:0] line_number;
        logic [15:0] first_address;
        logic [15:0] last_address;
        logic [16:0] byte_total;
        logic [7:0]  read_data;
    } ihl_out_t;

    // Input modes.
    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_END   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_START = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_ERROR  = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    // Status codes.
    localparam logic [4:0] STS_OK          = 5'd0;
    localparam logic [4:0] STS_AFTER_EOF   = 5'd1;
    localparam logic [4:0] STS_NO_COLON    = 5'd2;
    localparam logic [4:0] STS_BAD_LENGTH  = 5'd3;
    localparam logic [4:0] STS_HEADER_HEX  = 5'd4;
    localparam logic [4:0] STS_COUNT       = 5'd5;
    localparam logic [4:0] STS_BAD_HEX     = 5'd6;
    localparam logic [4:0] STS_CHECKSUM    = 5'd7;
    localparam logic [4:0] STS_ADDR_LIMIT  = 5'd8;
    localparam logic [4:0] STS_CONFLICT    = 5'd9;
    localparam logic [4:0] STS_BAD_EOF     = 5'd10;
    localparam logic [4:0] STS_SEG_ADDR    = 5'd11;
    localparam logic [4:0] STS_SEG_COUNT   = 5'd12;
    localparam logic [4:0] STS_LIN_ADDR    = 5'd13;
    localparam logic [4:0] STS_LIN_COUNT   = 5'd14;
    localparam logic [4:0] STS_BAD_START   = 5'd15;
    localparam logic [4:0] STS_BAD_TYPE    = 5'd16;
    localparam logic [4:0] STS_NO_EOF      = 5'd17;
    localparam logic [4:0] STS_NO_DATA     = 5'd18;

    // Record types.
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    // Characters and limits.
    localparam logic [7:0]  CH_LF     = 8'h0A;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
    localparam logic [9:0]  COUNT_CAP = 10'd1022;

    // Saturating character count add that keeps the parity of the sum.
    function automatic logic [9:0] cap_add(input logic [9:0] a, input logic [9:0] b);
        logic [10:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, COUNT_CAP}) begin
            cap_add = {COUNT_CAP[9:1], s[0]};
        end else begin
            cap_add = s[9:0];
        end
    endfunction

    // Space, tab, vertical tab, form feed and carriage return.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) ||
                   (c == 8'h0C) || (c == 8'h0D);
    endfunction

    // Hex digit value; 16 marks a character that is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            hex_val = {1'b0, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            hex_val = {1'b0, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            hex_val = {1'b0, d[3:0]};
        end else begin
            hex_val = 5'd16;
        end
    endfunction

endpackage

// ----- hdl/ihl_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module ihl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; the read returns the old contents.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/intel_hex_image_loader.sv -----
// Intel HEX image loader top level: record parser, commit sequencer, result register.
// Depends on ihl_pkg and ihl_ram (image memory and record buffer).
//
// Usage: the s_ channel carries one transaction per file character (mode 0), an end of
// input (mode 1), an image read (mode 2) or a restart (mode 3). The m_ channel returns an
// error at the newline that ends a bad record, the final load status at end of input,
// and read data. After reset and after a restart the block sweeps the image memory to
// clear its valid bits, one entry per cycle, with s_ready low.
// Throughput: one character per cycle while the block is idle in its run state. A newline
// or end of input goes through a finish step, and a data record first through a commit:
// each byte is visited twice through the single image memory port, once to check range
// and conflicts and once to write, and each visit is a read followed by a compare or write.
// A read goes through the same port. A result is registered in the cycle after that work.
// The result waits in an output register while the receiver stalls; characters and
// restarts are still taken, while transactions that can produce a result wait for it.
module intel_hex_image_loader #(
    parameter int ADDRESS_BITS = ihl_pkg::IHL_ADDRESS_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ihl_pkg::ihl_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ihl_pkg::ihl_out_t m_data
);
    import ihl_pkg::*;

    localparam int AB = ADDRESS_BITS;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_RUN, ST_READ, ST_CHK_RD, ST_CHK_CMP, ST_WR_RD, ST_WR_WR, ST_FINISH
    } state_t;

    typedef enum logic [1:0] {PH_IDLE, PH_LINE, PH_DONE} phase_t;

    state_t          state_reg, state_next;
    phase_t          phase_reg, phase_next;
    logic [9:0]      cc_reg, cc_next;
    logic [9:0]      pend_reg, pend_next;
    logic [3:0]      hold_reg, hold_next;
    logic [31:0]     hdr_reg, hdr_next;
    logic            nocolon_reg, nocolon_next;
    logic            hdrbad_reg, hdrbad_next;
    logic            bad_reg, bad_next;
    logic [7:0]      sum_reg, sum_next;
    logic [7:0]      dhi_reg, dhi_next;
    logic [7:0]      dlo_reg, dlo_next;
    logic [31:0]     base_reg, base_next;
    logic            eof_reg, eof_next;
    logic [AB-1:0]   low_reg, low_next;
    logic [AB-1:0]   high_reg, high_next;
    logic [AB:0]     dist_reg, dist_next;
    logic [23:0]     line_reg, line_next;
    logic [4:0]      latch_reg, latch_next;
    logic [AB-1:0]   clr_reg, clr_next;
    logic [7:0]      cnt_reg, cnt_next;
    logic [31:0]     start_reg, start_next;
    logic [31:0]     cur_reg, cur_next;
    logic [7:0]      idx_reg, idx_next;
    logic [4:0]      err_reg, err_next;
    logic            eoi_reg, eoi_next;
    logic            upd_reg, upd_next;
    logic            m_valid_reg, m_valid_next;
    ihl_out_t        m_data_reg, m_data_next;

    logic            accept;
    logic            out_free;
    logic            img_we;
    logic [AB-1:0]   img_addr;
    logic [8:0]      img_wdata, img_rdata;
    logic            rb_we;
    logic [7:0]      rb_addr, rb_waddr, rb_wdata, rb_rdata;

    logic [7:0]      h_cnt, h_type;
    logic [15:0]     h_addr;
    logic [4:0]      chk_e;
    logic [23:0]     cur_line;

    // Image memory: valid bit over data byte.
    ihl_ram #(.WIDTH(9), .DEPTH(2 ** AB)) u_image (
        .aclk (aclk),
        .we   (img_we),
        .addr (img_addr),
        .wdata(img_wdata),
        .rdata(img_rdata)
    );

    // Record buffer for the data bytes of the current line.
    ihl_ram #(.WIDTH(8), .DEPTH(255)) u_record (
        .aclk (aclk),
        .we   (rb_we),
        .addr (rb_addr),
        .wdata(rb_wdata),
        .rdata(rb_rdata)
    );

    // Handshake: result-free transactions pass even when the output register is full.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_RUN) &&
                      (out_free || s_data.mode == MODE_START ||
                       (s_data.mode == MODE_CHAR && s_data.character != CH_LF));
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Header fields and the record checks in file order of errors.
    assign h_cnt    = hdr_reg[31:24];
    assign h_addr   = hdr_reg[23:8];
    assign h_type   = hdr_reg[7:0];
    assign cur_line = (line_reg >= LINE_MAX) ? LINE_MAX : line_reg + 24'd1;

    always_comb begin
        if (eof_reg) begin
            chk_e = STS_AFTER_EOF;
        end else if (nocolon_reg) begin
            chk_e = STS_NO_COLON;
        end else if (cc_reg < 10'd10 || cc_reg[0]) begin
            chk_e = STS_BAD_LENGTH;
        end else if (hdrbad_reg) begin
            chk_e = STS_HEADER_HEX;
        end else if (cc_reg != {1'b0, h_cnt + 8'd5, 1'b0} &&
                     !(h_cnt > 8'd250 && cc_reg == {2'b01, h_cnt - 8'd251, 1'b0})) begin
            chk_e = STS_COUNT;
        end else if (bad_reg) begin
            chk_e = STS_BAD_HEX;
        end else if (sum_reg != 8'h00) begin
            chk_e = STS_CHECKSUM;
        end else begin
            unique case (h_type)
                REC_DATA: chk_e = STS_OK;
                REC_EOF:  chk_e = (h_cnt != 8'd0 || h_addr != 16'd0) ? STS_BAD_EOF : STS_OK;
                REC_ESA:  chk_e = (h_addr != 16'd0) ? STS_SEG_ADDR :
                                  (h_cnt != 8'd2) ? STS_SEG_COUNT : STS_OK;
                REC_ELA:  chk_e = (h_addr != 16'd0) ? STS_LIN_ADDR :
                                  (h_cnt != 8'd2) ? STS_LIN_COUNT : STS_OK;
                REC_SSA, REC_SLA:
                          chk_e = (h_cnt != 8'd4 || h_addr != 16'd0) ? STS_BAD_START : STS_OK;
                default:  chk_e = STS_BAD_TYPE;
            endcase
        end
    end

    // Next-state logic for the parser, commit sequencer and result register.
    always_comb begin
        logic [9:0]  cc1;
        logic        bad1;
        logic        hb1;
        logic [4:0]  nib;
        logic [7:0]  b;
        logic [8:0]  bidx;
        logic        do_end;
        logic        done_i;
        logic [31:0] tmp32;

        cc1    = cc_reg;
        bad1   = bad_reg;
        hb1    = hdrbad_reg;
        nib    = hex_val(s_data.character);
        b      = {hold_reg, nib[3:0]};
        bidx   = 9'd0;
        do_end = 1'b0;
        done_i = ({1'b0, idx_reg} + 9'd1) == {1'b0, cnt_reg};
        tmp32  = 32'd0;

        state_next   = state_reg;
        phase_next   = phase_reg;
        cc_next      = cc_reg;
        pend_next    = pend_reg;
        hold_next    = hold_reg;
        hdr_next     = hdr_reg;
        nocolon_next = nocolon_reg;
        hdrbad_next  = hdrbad_reg;
        bad_next     = bad_reg;
        sum_next     = sum_reg;
        dhi_next     = dhi_reg;
        dlo_next     = dlo_reg;
        base_next    = base_reg;
        eof_next     = eof_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        dist_next    = dist_reg;
        line_next    = line_reg;
        latch_next   = latch_reg;
        clr_next     = clr_reg;
        cnt_next     = cnt_reg;
        start_next   = start_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        err_next     = err_reg;
        eoi_next     = eoi_reg;
        upd_next     = upd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        img_we    = 1'b0;
        tmp32     = 32'(s_data.read_address);
        img_addr  = cur_reg[AB-1:0];
        img_wdata = {1'b1, rb_rdata};
        rb_we     = 1'b0;
        rb_waddr  = 8'd0;
        rb_wdata  = b;

        unique case (state_reg)
            // Sweep the image memory to clear every valid bit.
            ST_CLEAR: begin
                img_we    = 1'b1;
                img_addr  = clr_reg;
                img_wdata = 9'd0;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = ST_RUN;
                end
            end

            // Take one input transaction.
            ST_RUN: begin
                img_addr = tmp32[AB-1:0];
                if (accept) begin
                    unique case (s_data.mode)
                        MODE_READ: begin
                            state_next = ST_READ;
                        end
                        MODE_START: begin
                            state_next   = ST_CLEAR;
                            phase_next   = PH_IDLE;
                            cc_next      = '0;
                            pend_next    = '0;
                            hold_next    = '0;
                            hdr_next     = '0;
                            nocolon_next = 1'b0;
                            hdrbad_next  = 1'b0;
                            bad_next     = 1'b0;
                            sum_next     = '0;
                            base_next    = '0;
                            eof_next     = 1'b0;
                            low_next     = '1;
                            high_next    = '0;
                            dist_next    = '0;
                            line_next    = '0;
                            latch_next   = STS_OK;
                            clr_next     = '0;
                        end
                        MODE_END: begin
                            eoi_next   = 1'b1;
                            upd_next   = (phase_reg != PH_DONE);
                            err_next   = STS_OK;
                            state_next = ST_FINISH;
                            do_end     = (phase_reg != PH_DONE) && (latch_reg == STS_OK);
                        end
                        default: begin
                            if (phase_reg == PH_DONE || latch_reg != STS_OK) begin
                                // Characters are ignored once the load has ended or an error is latched.
                            end else if (s_data.character == CH_LF) begin
                                eoi_next   = 1'b0;
                                upd_next   = 1'b1;
                                err_next   = STS_OK;
                                state_next = ST_FINISH;
                                do_end     = 1'b1;
                            end else if (phase_reg == PH_IDLE) begin
                                if (!is_blank(s_data.character)) begin
                                    phase_next = PH_LINE;
                                    if (s_data.character != CH_COLON) begin
                                        nocolon_next = 1'b1;
                                    end
                                end
                            end else if (nocolon_reg) begin
                                // The line already failed its first character.
                            end else if (is_blank(s_data.character)) begin
                                pend_next = cap_add(pend_reg, 10'd1);
                            end else begin
                                // Inner whitespace counts as bad hex characters.
                                if (pend_reg != 10'd0) begin
                                    bad1 = 1'b1;
                                    if (cc_reg < 10'd8) begin
                                        hb1 = 1'b1;
                                    end
                                    cc1 = cap_add(cc_reg, pend_reg);
                                end
                                pend_next = '0;
                                if (nib[4]) begin
                                    bad1 = 1'b1;
                                    if (cc1 < 10'd8) begin
                                        hb1 = 1'b1;
                                    end
                                end else if (!bad1 && cc1 < 10'd520) begin
                                    if (!cc1[0]) begin
                                        hold_next = nib[3:0];
                                    end else begin
                                        bidx     = cc1[9:1];
                                        sum_next = sum_reg + b;
                                        if (bidx < 9'd4) begin
                                            case (bidx[1:0])
                                                2'd0:    hdr_next[31:24] = b;
                                                2'd1:    hdr_next[23:16] = b;
                                                2'd2:    hdr_next[15:8]  = b;
                                                default: hdr_next[7:0]   = b;
                                            endcase
                                        end else if (bidx < 9'd259) begin
                                            tmp32    = 32'(bidx - 9'd4);
                                            rb_we    = 1'b1;
                                            rb_waddr = tmp32[7:0];
                                            if (bidx == 9'd4) begin
                                                dhi_next = b;
                                            end
                                            if (bidx == 9'd5) begin
                                                dlo_next = b;
                                            end
                                        end
                                    end
                                end
                                cc_next     = cap_add(cc1, 10'd1);
                                bad_next    = bad1;
                                hdrbad_next = hb1;
                            end
                        end
                    endcase

                    // Line end: check the record, apply its effects, start a commit for a data record.
                    if (do_end) begin
                        if (phase_reg == PH_LINE) begin
                            err_next = chk_e;
                            if (chk_e == STS_OK) begin
                                if (h_type == REC_EOF) begin
                                    eof_next = 1'b1;
                                end
                                if (h_type == REC_ESA) begin
                                    base_next = {12'd0, dhi_reg, dlo_reg, 4'd0};
                                end
                                if (h_type == REC_ELA) begin
                                    base_next = {dhi_reg, dlo_reg, 16'd0};
                                end
                                if (h_type == REC_DATA && h_cnt != 8'd0) begin
                                    cnt_next   = h_cnt;
                                    start_next = base_reg + 32'(h_addr);
                                    cur_next   = base_reg + 32'(h_addr);
                                    idx_next   = '0;
                                    state_next = ST_CHK_RD;
                                end
                            end
                        end
                        phase_next   = PH_IDLE;
                        cc_next      = '0;
                        pend_next    = '0;
                        hold_next    = '0;
                        hdr_next     = '0;
                        nocolon_next = 1'b0;
                        hdrbad_next  = 1'b0;
                        bad_next     = 1'b0;
                        sum_next     = '0;
                    end
                end
            end

            // Image read data returns in the cycle after the address.
            ST_READ: begin
                m_valid_next          = 1'b1;
                m_data_next           = '0;
                m_data_next.kind      = KIND_READ;
                m_data_next.read_data = img_rdata[8] ? img_rdata[7:0] : 8'hFF;
                state_next            = ST_RUN;
            end

            // Check pass: range test, then read stored byte and buffered byte.
            ST_CHK_RD: begin
                rb_waddr = idx_reg;
                if (cur_reg[31:AB] != '0) begin
                    err_next   = STS_ADDR_LIMIT;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CHK_CMP;
                end
            end

            ST_CHK_CMP: begin
                rb_waddr = idx_reg;
                if (img_rdata[8] && img_rdata[7:0] != rb_rdata) begin
                    err_next   = STS_CONFLICT;
                    state_next = ST_FINISH;
                end else if (done_i) begin
                    idx_next   = '0;
                    cur_next   = start_reg;
                    state_next = ST_WR_RD;
                end else begin
                    idx_next   = idx_reg + 8'd1;
                    cur_next   = cur_reg + 32'd1;
                    state_next = ST_CHK_RD;
                end
            end

            // Write pass: read old valid bit and buffered byte, then write.
            ST_WR_RD: begin
                rb_waddr   = idx_reg;
                state_next = ST_WR_WR;
            end

            ST_WR_WR: begin
                rb_waddr = idx_reg;
                img_we   = 1'b1;
                if (!img_rdata[8]) begin
                    dist_next = dist_reg + 1'b1;
                end
                if (cur_reg[AB-1:0] < low_reg) begin
                    low_next = cur_reg[AB-1:0];
                end
                if (cur_reg[AB-1:0] > high_reg) begin
                    high_next = cur_reg[AB-1:0];
                end
                idx_next = idx_reg + 8'd1;
                cur_next = cur_reg + 32'd1;
                if (done_i) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_WR_RD;
                end
            end

            // Report an error at a newline, or the final status at end of input.
            default: begin
                state_next = ST_RUN;
                if (eoi_reg) begin
                    if (upd_reg && latch_reg == STS_OK) begin
                        if (err_reg != STS_OK) begin
                            latch_next = err_reg;
                        end else if (!eof_reg) begin
                            latch_next = STS_NO_EOF;
                        end else if (dist_reg == '0) begin
                            latch_next = STS_NO_DATA;
                        end
                    end
                    phase_next                = PH_DONE;
                    m_valid_next              = 1'b1;
                    m_data_next               = '0;
                    m_data_next.kind          = KIND_STATUS;
                    m_data_next.status        = latch_next;
                    if (latch_next >= STS_AFTER_EOF && latch_next <= STS_BAD_TYPE) begin
                        m_data_next.line_number = cur_line;
                    end
                    tmp32                     = 32'(low_reg);
                    m_data_next.first_address = tmp32[15:0];
                    tmp32                     = 32'(high_reg);
                    m_data_next.last_address  = tmp32[15:0];
                    tmp32                     = 32'(dist_reg);
                    m_data_next.byte_total    = tmp32[16:0];
                end else if (err_reg != STS_OK) begin
                    latch_next              = err_reg;
                    m_valid_next            = 1'b1;
                    m_data_next             = '0;
                    m_data_next.kind        = KIND_ERROR;
                    m_data_next.status      = err_reg;
                    m_data_next.line_number = cur_line;
                end else if (line_reg < LINE_MAX) begin
                    line_next = line_reg + 24'd1;
                end
            end
        endcase

        rb_addr = rb_waddr;
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            phase_reg   <= PH_IDLE;
            cc_reg      <= '0;
            pend_reg    <= '0;
            hold_reg    <= '0;
            hdr_reg     <= '0;
            nocolon_reg <= 1'b0;
            hdrbad_reg  <= 1'b0;
            bad_reg     <= 1'b0;
            sum_reg     <= '0;
            base_reg    <= '0;
            eof_reg     <= 1'b0;
            low_reg     <= '1;
            high_reg    <= '0;
            dist_reg    <= '0;
            line_reg    <= '0;
            latch_reg   <= STS_OK;
            clr_reg     <= '0;
            eoi_reg     <= 1'b0;
            upd_reg     <= 1'b0;
            err_reg     <= STS_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cc_reg      <= cc_next;
            pend_reg    <= pend_next;
            hold_reg    <= hold_next;
            hdr_reg     <= hdr_next;
            nocolon_reg <= nocolon_next;
            hdrbad_reg  <= hdrbad_next;
            bad_reg     <= bad_next;
            sum_reg     <= sum_next;
            base_reg    <= base_next;
            eof_reg     <= eof_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            dist_reg    <= dist_next;
            line_reg    <= line_next;
            latch_reg   <= latch_next;
            clr_reg     <= clr_next;
            eoi_reg     <= eoi_next;
            upd_reg     <= upd_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
        dhi_reg    <= dhi_next;
        dlo_reg    <= dlo_next;
        cnt_reg    <= cnt_next;
        start_reg  <= start_next;
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    // A read transaction returns its data through ST_READ and the output register.
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.mode == MODE_READ) |=> ##1 m_valid_reg)
        else $error("read data not returned in time");

    // Once an error is latched it only clears through a restart.
    a_latch_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (latch_reg != STS_OK && !(s_valid && s_ready && s_data.mode == MODE_START))
        |=> latch_reg == $past(latch_reg))
        else $error("latched status changed without restart");

    // The image memory is written only by the clearing sweep or the commit pass.
    a_commit_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR_WR) |-> ($past(state_reg) == ST_WR_RD && latch_reg == STS_OK))
        else $error("image write outside the commit pass");
`endif

endmodule

// ----- sim/hex_load_checker.sv -----
// Checker for the Intel HEX image loader: watches both channels, predicts each result
// and compares it field by field. Depends on ihl_pkg.
module hex_load_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  ihl_pkg::ihl_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  ihl_pkg::ihl_out_t m_data,
    output int                fail_count,
    output int                outstanding
);
    import ihl_pkg::*;

    typedef enum logic [1:0] {LN_IDLE, LN_BODY, LN_DONE} line_state_t;

    localparam logic [3:0] FLG_NOCOLON = 4'd1;
    localparam logic [3:0] FLG_HDRBAD  = 4'd2;
    localparam logic [3:0] FLG_BAD     = 4'd4;
    localparam int         SAT_COUNT   = 1022;

    // Predicted image and per-line record state.
    logic [7:0]  img_byte [0:65535];
    bit          img_set [0:65535];
    logic [7:0]  rec_data [0:254];
    line_state_t phase;
    logic [9:0]  char_cnt, blank_run;
    logic [3:0]  hi_nibble, flags;
    logic [31:0] header, base_addr;
    logic [7:0]  csum;
    bit          eof_done;
    logic [15:0] lo_addr, hi_addr;
    logic [16:0] loaded;
    logic [23:0] lines_done;
    logic [4:0]  latched;

    ihl_out_t expected_q[$];

    // Saturating count add that keeps the parity of the sum.
    function automatic logic [9:0] sat_add(input logic [9:0] a, input logic [9:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s >= SAT_COUNT) begin
            return 10'(SAT_COUNT | (s & 1));
        end
        return 10'(s);
    endfunction

    function automatic bit blank_char(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'd16;
    endfunction

    function automatic logic [23:0] error_line();
        return (lines_done == LINE_MAX) ? LINE_MAX : lines_done + 24'd1;
    endfunction

    task automatic clear_line();
        phase = LN_IDLE;
        char_cnt = '0;
        blank_run = '0;
        hi_nibble = '0;
        header = '0;
        flags = '0;
        csum = '0;
    endtask

    task automatic clear_load();
        for (int i = 0; i < 65536; i++) begin
            img_set[i] = 1'b0;
        end
        clear_line();
        base_addr = '0;
        eof_done = 1'b0;
        lo_addr = 16'hFFFF;
        hi_addr = '0;
        loaded = '0;
        lines_done = '0;
        latched = STS_OK;
    endtask

    // Whitespace inside a record is folded in as bad characters once content follows.
    task automatic flush_blanks();
        if (blank_run != 0) begin
            flags |= FLG_BAD;
            if (char_cnt < 8) flags |= FLG_HDRBAD;
            char_cnt = sat_add(char_cnt, blank_run);
            blank_run = '0;
        end
    endtask

    task automatic take_nibble(input logic [4:0] v);
        logic [7:0] b;
        int idx;
        if (v > 15) begin
            flags |= FLG_BAD;
            if (char_cnt < 8) flags |= FLG_HDRBAD;
        end else if ((flags & FLG_BAD) == 0 && char_cnt < 520) begin
            if (!char_cnt[0]) begin
                hi_nibble = v[3:0];
            end else begin
                b = {hi_nibble, v[3:0]};
                idx = int'(char_cnt) >> 1;
                csum = csum + b;
                if (idx < 4) begin
                    header |= 32'(b) << (24 - 8 * idx);
                end else if (idx - 4 < 255) begin
                    rec_data[idx - 4] = b;
                end
            end
        end
        char_cnt = sat_add(char_cnt, 10'd1);
    endtask

    // Checks a finished record in file order and commits it when valid.
    task automatic close_record(output logic [4:0] st);
        logic [7:0]  cnt, rtype;
        logic [15:0] roff;
        logic [31:0] a;
        st = STS_OK;
        cnt = header[31:24];
        roff = header[23:8];
        rtype = header[7:0];
        if (eof_done) begin
            st = STS_AFTER_EOF; return;
        end
        if ((flags & FLG_NOCOLON) != 0) begin
            st = STS_NO_COLON; return;
        end
        if (char_cnt < 10 || char_cnt[0]) begin
            st = STS_BAD_LENGTH; return;
        end
        if ((flags & FLG_HDRBAD) != 0) begin
            st = STS_HEADER_HEX; return;
        end
        if (int'(char_cnt) != 2 * (5 + int'(cnt))) begin
            st = STS_COUNT; return;
        end
        if ((flags & FLG_BAD) != 0) begin
            st = STS_BAD_HEX; return;
        end
        if (csum != 0) begin
            st = STS_CHECKSUM; return;
        end
        case (rtype)
            REC_DATA: begin
                for (int i = 0; i < cnt; i++) begin
                    a = base_addr + 32'(roff) + 32'(i);
                    if (a > 32'hFFFF) begin
                        st = STS_ADDR_LIMIT; return;
                    end
                    if (img_set[a[15:0]] && img_byte[a[15:0]] != rec_data[i]) begin
                        st = STS_CONFLICT; return;
                    end
                end
                for (int i = 0; i < cnt; i++) begin
                    a = base_addr + 32'(roff) + 32'(i);
                    if (!img_set[a[15:0]]) loaded++;
                    img_set[a[15:0]] = 1'b1;
                    img_byte[a[15:0]] = rec_data[i];
                    if (a[15:0] < lo_addr) lo_addr = a[15:0];
                    if (a[15:0] > hi_addr) hi_addr = a[15:0];
                end
            end
            REC_EOF: begin
                if (cnt != 0 || roff != 0) st = STS_BAD_EOF;
                else eof_done = 1'b1;
            end
            REC_ESA: begin
                if (roff != 0) st = STS_SEG_ADDR;
                else if (cnt != 2) st = STS_SEG_COUNT;
                else base_addr = {12'd0, rec_data[0], rec_data[1], 4'd0};
            end
            REC_ELA: begin
                if (roff != 0) st = STS_LIN_ADDR;
                else if (cnt != 2) st = STS_LIN_COUNT;
                else base_addr = {rec_data[0], rec_data[1], 16'd0};
            end
            REC_SSA, REC_SLA: begin
                if (cnt != 4 || roff != 0) st = STS_BAD_START;
            end
            default: st = STS_BAD_TYPE;
        endcase
    endtask

    task automatic end_line(output logic [4:0] st);
        st = STS_OK;
        if (phase == LN_BODY) close_record(st);
        clear_line();
    endtask

    // Advances the prediction by one accepted input transaction.
    task automatic predict_transaction(input ihl_in_t d);
        ihl_out_t r;
        logic [4:0] st;
        r = '0;
        case (d.mode)
            MODE_READ: begin
                r.kind = KIND_READ;
                r.read_data = img_set[d.read_address] ? img_byte[d.read_address] : 8'hFF;
                expected_q.push_back(r);
            end
            MODE_START: clear_load();
            MODE_END: begin
                if (phase != LN_DONE) begin
                    if (latched == STS_OK) end_line(latched);
                    if (latched == STS_OK) begin
                        if (!eof_done) latched = STS_NO_EOF;
                        else if (loaded == 0) latched = STS_NO_DATA;
                    end
                    phase = LN_DONE;
                end
                r.kind = KIND_STATUS;
                r.status = latched;
                if (latched >= STS_AFTER_EOF && latched <= STS_BAD_TYPE) begin
                    r.line_number = error_line();
                end
                r.first_address = lo_addr;
                r.last_address = hi_addr;
                r.byte_total = loaded;
                expected_q.push_back(r);
            end
            default: begin
                if (phase != LN_DONE && latched == STS_OK) begin
                    if (d.character == CH_LF) begin
                        end_line(st);
                        if (st != STS_OK) begin
                            latched = st;
                            r.kind = KIND_ERROR;
                            r.status = st;
                            r.line_number = error_line();
                            expected_q.push_back(r);
                        end else if (lines_done != LINE_MAX) begin
                            lines_done++;
                        end
                    end else if (phase == LN_IDLE) begin
                        if (!blank_char(d.character)) begin
                            phase = LN_BODY;
                            if (d.character != CH_COLON) flags |= FLG_NOCOLON;
                        end
                    end else if ((flags & FLG_NOCOLON) == 0) begin
                        if (blank_char(d.character)) begin
                            blank_run = sat_add(blank_run, 10'd1);
                        end else begin
                            flush_blanks();
                            take_nibble(nibble_of(d.character));
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at %0t: %s is %0h, expected %0h", $time, field, got, want);
        fail_count++;
    endtask

    task automatic compare_result(input ihl_out_t got);
        ihl_out_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("unexpected result kind", got.kind, 0);
            return;
        end
        want = expected_q.pop_front();
        if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.line_number !== want.line_number)
            report_mismatch("line_number", got.line_number, want.line_number);
        if (got.first_address !== want.first_address)
            report_mismatch("first_address", got.first_address, want.first_address);
        if (got.last_address !== want.last_address)
            report_mismatch("last_address", got.last_address, want.last_address);
        if (got.byte_total !== want.byte_total)
            report_mismatch("byte_total", got.byte_total, want.byte_total);
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
    endtask

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    // Results are checked before the input of the same edge is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_load();
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) compare_result(m_data);
            if (s_valid && s_ready) predict_transaction(s_data);
        end
        outstanding <= expected_q.size();
    end

endmodule

// ----- sim/tb_intel_hex_image_loader.sv -----
// Testbench top for the Intel HEX image loader: clock, reset, record stimulus and verdict.
// Depends on ihl_pkg, intel_hex_image_loader and hex_load_checker.
module tb_intel_hex_image_loader;
    import ihl_pkg::*;

    typedef enum int {
        FL_NONE, FL_NO_COLON, FL_ODD, FL_HDR_HEX, FL_COUNT, FL_DATA_HEX, FL_INNER_BLANK,
        FL_CHECKSUM
    } flaw_t;

    localparam int CYCLE_LIMIT   = 5000000;
    localparam int RANDOM_ITEMS  = 60;
    localparam int HOLD_CYCLES   = 400;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    ihl_in_t   s_data;
    logic      m_valid;
    logic      m_ready;
    ihl_out_t  m_data;
    int        fail_count;
    int        outstanding;
    int        cycles;
    int        sent;
    bit        quiet;
    bit        hold_req;

    logic [7:0] blanks [5] = '{8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D};

    intel_hex_image_loader uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    hex_load_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request, none in the quiet part.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one input transaction and waits until it is accepted.
    task automatic send(input logic [1:0] md, input logic [7:0] ch, input logic [15:0] ra);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{mode: md, character: ch, read_address: ra};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic send_char(input logic [7:0] c);
        send(MODE_CHAR, c, 16'($urandom));
    endtask

    task automatic send_op(input logic [1:0] md, input logic [15:0] ra);
        send(md, 8'($urandom), ra);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return 8'("0" + v);
        return ($urandom_range(0, 1) != 0) ? 8'("a" + v - 10) : 8'("A" + v - 10);
    endfunction

    // A character that is neither hex, blank, newline nor colon.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                   (c >= "A" && c <= "F") || c == CH_LF || c == CH_COLON ||
                   c == 8'h20 || (c >= 8'h09 && c <= 8'h0D));
        return c;
    endfunction

    // Builds one record as text, applies an optional flaw and sends it.
    task automatic emit_record(input logic [7:0] rtype, input logic [15:0] roff,
                               input int n, input logic [15:0] word, input flaw_t flaw,
                               input bit newline);
        logic [7:0] bytes_q[$];
        logic [7:0] text_q[$];
        logic [7:0] sum;
        int pos;
        bytes_q.push_back(8'(flaw == FL_COUNT ? n + 1 : n));
        bytes_q.push_back(roff[15:8]);
        bytes_q.push_back(roff[7:0]);
        bytes_q.push_back(rtype);
        for (int i = 0; i < n; i++) begin
            if ((rtype == REC_ESA || rtype == REC_ELA) && i < 2) begin
                bytes_q.push_back(i == 0 ? word[15:8] : word[7:0]);
            end else begin
                bytes_q.push_back(8'($urandom));
            end
        end
        sum = '0;
        foreach (bytes_q[i]) sum += bytes_q[i];
        sum = -sum;
        if (flaw == FL_CHECKSUM) sum = sum + 8'($urandom_range(1, 255));
        bytes_q.push_back(sum);
        text_q.push_back(CH_COLON);
        foreach (bytes_q[i]) begin
            text_q.push_back(hex_char(bytes_q[i][7:4]));
            text_q.push_back(hex_char(bytes_q[i][3:0]));
        end
        case (flaw)
            FL_NO_COLON: text_q[0] = junk_char();
            FL_ODD: text_q.delete(text_q.size() - 1);
            FL_HDR_HEX: text_q[$urandom_range(1, 8)] = junk_char();
            FL_DATA_HEX: text_q[$urandom_range(9, text_q.size() - 1)] = junk_char();
            FL_INNER_BLANK: begin
                pos = $urandom_range(2, text_q.size() - 1);
                text_q.insert(pos, blanks[$urandom_range(0, 4)]);
            end
            default: ;
        endcase
        // Blanks around the record are legal and trimmed.
        if ($urandom_range(0, 4) == 0) text_q.push_front(blanks[$urandom_range(0, 4)]);
        if ($urandom_range(0, 4) == 0) text_q.push_back(blanks[$urandom_range(0, 4)]);
        foreach (text_q[i]) send_char(text_q[i]);
        if (newline) send_char(CH_LF);
    endtask

    // Records that pass the checks up to the rules of their type and then break one.
    task automatic emit_bad_type_rule();
        case ($urandom_range(0, 8))
            0: emit_record(REC_EOF, 16'h0000, 1, 0, FL_NONE, 1);
            1: emit_record(REC_EOF, 16'($urandom_range(1, 65535)), 0, 0, FL_NONE, 1);
            2: emit_record(REC_ESA, 16'($urandom_range(1, 65535)), 2, 0, FL_NONE, 1);
            3: emit_record(REC_ESA, 16'h0000, 3, 0, FL_NONE, 1);
            4: emit_record(REC_ELA, 16'($urandom_range(1, 65535)), 2, 0, FL_NONE, 1);
            5: emit_record(REC_ELA, 16'h0000, 1, 0, FL_NONE, 1);
            6: emit_record(REC_SSA, 16'h0000, 3, 0, FL_NONE, 1);
            7: emit_record(REC_SLA, 16'h0010, 4, 0, FL_NONE, 1);
            default: emit_record(8'($urandom_range(6, 255)), 16'h0000, 2, 0, FL_NONE, 1);
        endcase
    endtask

    // One load: restart, a run of mostly valid records, then end of input and reads.
    task automatic random_load(input int lines);
        int act, n;
        logic [15:0] nxt;
        send_op(MODE_START, 16'($urandom));
        nxt = 16'($urandom_range(0, 16'h7000));
        for (int l = 0; l < lines; l++) begin
            act = $urandom_range(0, 99);
            n = $urandom_range(1, 16);
            if (act < 55) begin
                if ($urandom_range(0, 15) == 0) n = 0;
                emit_record(REC_DATA, nxt, n, 0, FL_NONE, 1);
                nxt += 16'(n);
            end else if (act < 60) begin
                emit_record(REC_ESA, 0, 2, 16'($urandom_range(0, 16'h07FF)), FL_NONE, 1);
            end else if (act < 63) begin
                emit_record(REC_ELA, 0, 2, ($urandom_range(0, 7) == 0) ? 16'h0001 : 16'h0000,
                            FL_NONE, 1);
            end else if (act < 66) begin
                emit_record(($urandom_range(0, 1) != 0) ? REC_SSA : REC_SLA, 0, 4, 0,
                            FL_NONE, 1);
            end else if (act < 68) begin
                repeat ($urandom_range(0, 3)) send_char(blanks[$urandom_range(0, 4)]);
                send_char(CH_LF);
            end else if (act < 71) begin
                repeat ($urandom_range(1, 4)) begin
                    send_op(MODE_READ, ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                            nxt - 16'($urandom_range(0, 40)));
                end
            end else if (act < 74) begin
                emit_record(REC_DATA, nxt - 16'($urandom_range(1, 8)), $urandom_range(1, 4),
                            0, FL_NONE, 1);
            end else if (act < 77) begin
                emit_record(REC_DATA, 16'hFFFF - 16'($urandom_range(0, 20)), n, 0,
                            FL_NONE, 1);
            end else if (act < 88) begin
                emit_record(REC_DATA, nxt, n, 0,
                            flaw_t'($urandom_range(FL_NO_COLON, FL_CHECKSUM)), 1);
            end else if (act < 95) begin
                emit_bad_type_rule();
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_char(8'($urandom_range(0, 254)) == CH_LF ? 8'hFF :
                              8'($urandom_range(0, 255)) | 8'h00);
                end
                send_char(CH_LF);
            end
        end
        if ($urandom_range(0, 9) != 0) emit_record(REC_EOF, 0, 0, 0, FL_NONE, 1);
        if ($urandom_range(0, 5) == 0) emit_record(REC_DATA, nxt, 2, 0, FL_NONE, 1);
        if ($urandom_range(0, 5) == 0) emit_record(REC_DATA, nxt, 3, 0, FL_NONE, 0);
        send_op(MODE_END, 16'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            send_char(8'($urandom));
            send_op(MODE_END, 16'($urandom));
        end
        repeat ($urandom_range(1, 6)) send_op(MODE_READ, nxt - 16'($urandom_range(0, 64)));
    endtask

    // Main stimulus and verdict.
    initial begin
        int start_count;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: every record type valid, the image extremes, repeated end of input.
        emit_record(REC_DATA, 16'h0000, 2, 0, FL_NONE, 1);
        emit_record(REC_DATA, 16'hFFFE, 2, 0, FL_NONE, 1);
        emit_record(REC_ESA, 16'h0000, 2, 16'h0000, FL_NONE, 1);
        emit_record(REC_ELA, 16'h0000, 2, 16'h0000, FL_NONE, 1);
        emit_record(REC_SSA, 16'h0000, 4, 0, FL_NONE, 1);
        emit_record(REC_SLA, 16'h0000, 4, 0, FL_NONE, 1);
        emit_record(REC_EOF, 16'h0000, 0, 0, FL_NONE, 1);
        send_op(MODE_END, 16'h0000);
        send_char(":");
        send_op(MODE_END, 16'hFFFF);
        send_op(MODE_READ, 16'h0000);
        send_op(MODE_READ, 16'hFFFF);
        send_op(MODE_READ, 16'h1234);

        // Directed: an overlong line saturates the count; no EOF; EOF without data.
        send_op(MODE_START, 16'h0000);
        send_char(CH_COLON);
        repeat (1030) send_char("0");
        send_char(CH_LF);
        send_op(MODE_END, 16'h0000);
        send_op(MODE_START, 16'h0000);
        send_op(MODE_END, 16'h0000);
        send_op(MODE_START, 16'h0000);
        emit_record(REC_EOF, 16'h0000, 0, 0, FL_NONE, 1);
        send_op(MODE_END, 16'h0000);

        // Receiver holds off while reads keep coming, so the input stalls.
        hold_req = 1'b1;
        repeat (30) send_op(MODE_READ, 16'($urandom));

        start_count = sent;
        while (sent - start_count < RANDOM_ITEMS) begin
            random_load($urandom_range(2, 5));
        end

        // Last part of the run: no idling on either side.
        quiet = 1'b1;
        random_load($urandom_range(2, 5));
        s_valid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ihl_pkg.sv
hdl/ihl_ram.sv
hdl/intel_hex_image_loader.sv
sim/hex_load_checker.sv
sim/tb_intel_hex_image_loader.sv
